[hw/rtl/dwr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared types, mode codes and screen geometry for the display window
// rescaler: configuration record, pipeline stage records, mode decode.
// ----------------------------------------------------------------------------
package dwr_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_ADDR_W-1:0] CFG_GAME_MODE       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAME_INTERLACE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAME_FRAME_MODE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_MODE        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_INTERLACE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_FRAME_MODE  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPSCALE_CHOICE  = 3'd6;

    // Video mode codes
    localparam logic [6:0] MODE_480I  = 7'h02;
    localparam logic [6:0] MODE_576I  = 7'h03;
    localparam logic [6:0] MODE_480P  = 7'h50;
    localparam logic [6:0] MODE_1080I = 7'h51;
    localparam logic [6:0] MODE_576P  = 7'h53;

    // Reset values of the mode registers
    localparam logic [6:0] RESET_MODE = MODE_480I;

    // Upscale choices
    localparam logic [2:0] UP_240P     = 3'd0;
    localparam logic [2:0] UP_480P     = 3'd1;
    localparam logic [2:0] UP_1080I_X1 = 3'd2;
    localparam logic [2:0] UP_1080I_X2 = 3'd3;
    localparam logic [2:0] UP_1080I_X3 = 3'd4;

    // Screen geometry
    localparam int SD_WIDTH    = 720;
    localparam int NTSC_HEIGHT = 480;
    localparam int NTSC_X_OFS  = 123;
    localparam int NTSC_Y_OFS  = 34;
    localparam int PAL_HEIGHT  = 576;
    localparam int PAL_X_OFS   = 130;
    localparam int PAL_Y_OFS   = 40;
    localparam int HD_WIDTH    = 1920;
    localparam int HD_HEIGHT   = 1080;
    localparam int HD_X_OFS    = 236;
    localparam int HD_Y_OFS    = 38;

    // Datapath widths
    localparam int CTR_W      = 12;   // screen center
    localparam int DIVIDEND_W = 18;   // width times new magnification
    localparam int QUOT_W     = 14;   // new width, at most three times input
    localparam int DIV_STEPS  = 6;    // quotient bits per divider stage

    typedef struct packed {
        logic [6:0] game_mode;
        logic       game_interlace;
        logic       game_frame_mode;
        logic [6:0] out_mode;
        logic       out_interlace;
        logic       out_frame_mode;
        logic [2:0] upscale_choice;
    } cfg_t;

    typedef struct packed {
        logic             ok;
        logic [1:0]       vck_log;    // log2 of pixel clock divider
        logic [2:0]       fb_h;       // framebuffer height class
        logic [2:0]       dp_h;       // display height class
        logic [CTR_W-1:0] x_center;
        logic [CTR_W-1:0] y_ctr;
    } mode_info_t;

    typedef struct packed {
        logic [3:0]  h_mag;
        logic [1:0]  v_mag;
        logic [11:0] width_m1;
        logic [10:0] height_m1;
    } item_t;

    // After mode decode and scaling
    typedef struct packed {
        logic             unsup;
        item_t            item;
        logic [4:0]       magh;
        logic [5:0]       magh_n;
        logic [1:0]       v_mag_n_m1;
        logic [13:0]      height_n;
        logic [CTR_W-1:0] x_center;
        logic [CTR_W-1:0] y_ctr;
    } scale_t;

    // Travels through the divider stages
    typedef struct packed {
        logic                  unsup;
        item_t                 item;
        logic [3:0]            h_mag_n_m1;
        logic [1:0]            v_mag_n_m1;
        logic [10:0]           height_n_m1;
        logic [10:0]           y_pos;
        logic [CTR_W-1:0]      x_center;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVIDEND_W-1:0] quotient;
        logic [3:0]            rem;
        logic [4:0]            divisor;
    } div_t;

    // Per mode: pixel clock divider, height classes and screen center
    function automatic mode_info_t describe_mode(logic [6:0] code, logic ilace,
                                                 logic frame);
        mode_info_t m;
        m.ok       = 1'b0;
        m.vck_log  = 2'd0;
        m.fb_h     = 3'd1;
        m.dp_h     = 3'd1;
        m.x_center = '0;
        m.y_ctr    = '0;
        case (code)
            MODE_480I, MODE_480P: begin
                m.ok       = 1'b1;
                m.vck_log  = (code == MODE_480I) ? 2'd2 : 2'd1;
                m.fb_h     = 3'd2;
                m.dp_h     = 3'd2;
                m.x_center = CTR_W'((NTSC_X_OFS + SD_WIDTH / 2) << m.vck_log);
                if (code == MODE_480I && !ilace) begin
                    m.y_ctr = CTR_W'(NTSC_Y_OFS / 2 + NTSC_HEIGHT / 4);
                end else begin
                    m.y_ctr = CTR_W'(NTSC_Y_OFS + NTSC_HEIGHT / 2);
                end
            end
            MODE_576I, MODE_576P: begin
                m.ok       = 1'b1;
                m.vck_log  = (code == MODE_576I) ? 2'd2 : 2'd1;
                m.fb_h     = 3'd2;
                m.dp_h     = 3'd2;
                m.x_center = CTR_W'((PAL_X_OFS + SD_WIDTH / 2) << m.vck_log);
                if (code == MODE_576I && !ilace) begin
                    m.y_ctr = CTR_W'(PAL_Y_OFS / 2 + PAL_HEIGHT / 4);
                end else begin
                    m.y_ctr = CTR_W'(PAL_Y_OFS + PAL_HEIGHT / 2);
                end
            end
            MODE_1080I: begin
                m.ok       = 1'b1;
                m.vck_log  = 2'd0;
                m.fb_h     = 3'd4;
                m.dp_h     = 3'd4;
                m.x_center = CTR_W'(HD_X_OFS + HD_WIDTH / 2);
                m.y_ctr    = CTR_W'(HD_Y_OFS + HD_HEIGHT / 2);
            end
            default: begin
                m.ok = 1'b0;
            end
        endcase
        // interlaced frame mode reads every other framebuffer line
        if (m.ok && ilace && frame) begin
            m.fb_h = m.fb_h >> 1;
        end
        // progressive use of an interlaced mode halves both classes
        if ((code == MODE_480I || code == MODE_576I) && !ilace) begin
            m.fb_h = m.fb_h >> 1;
            m.dp_h = m.dp_h >> 1;
        end
        return m;
    endfunction

    // Height classes are 1, 2 or 4
    function automatic logic [1:0] class_log(logic [2:0] h);
        logic [1:0] l;
        case (h)
            3'd4:    l = 2'd2;
            3'd2:    l = 2'd1;
            default: l = 2'd0;
        endcase
        return l;
    endfunction

endpackage

[hw/rtl/dwr_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwr_decode
// First stage: decodes game and output modes, derives the ratios and
// scales magnifications and height. Registered, with valid and ready.
// ----------------------------------------------------------------------------
module dwr_decode (
    input  logic             aclk,
    input  logic             aresetn,
    input  dwr_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  dwr_pkg::item_t   in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output dwr_pkg::scale_t  out_data
);

    dwr_pkg::mode_info_t g_info;
    dwr_pkg::mode_info_t o_info;
    logic [2:0]          o_fb;
    logic [2:0]          o_dp;
    logic [1:0]          hmul;
    logic [1:0]          vshift;
    logic [1:0]          g_fb_log;
    logic [1:0]          o_fb_log;
    logic [1:0]          g_dp_log;
    logic [1:0]          o_dp_log;
    logic [4:0]          magh;
    logic [6:0]          magh_x;
    logic [2:0]          magv;
    logic [4:0]          magv_n;
    logic [11:0]         dh;
    logic [13:0]         dh_n;
    logic                unsup;

    logic                valid_reg;
    dwr_pkg::scale_t     data_reg;
    dwr_pkg::scale_t     data_next;

    // mode decode
    always_comb begin
        g_info = dwr_pkg::describe_mode(cfg.game_mode, cfg.game_interlace,
                                        cfg.game_frame_mode);
        o_info = dwr_pkg::describe_mode(cfg.out_mode, cfg.out_interlace,
                                        cfg.out_frame_mode);
        o_fb   = o_info.fb_h;
        o_dp   = o_info.dp_h;
        hmul   = 2'd1;
        case (cfg.upscale_choice)
            dwr_pkg::UP_1080I_X1: begin
                o_fb = o_info.fb_h >> 1;
                o_dp = o_info.dp_h >> 1;
            end
            dwr_pkg::UP_1080I_X2: hmul = 2'd2;
            dwr_pkg::UP_1080I_X3: hmul = 2'd3;
            default:              hmul = 2'd1;
        endcase
        unsup = !g_info.ok || !o_info.ok || (g_info.vck_log < o_info.vck_log)
                || (o_fb == 3'd0) || (o_dp == 3'd0);
        vshift   = g_info.vck_log - o_info.vck_log;
        g_fb_log = dwr_pkg::class_log(g_info.fb_h);
        o_fb_log = dwr_pkg::class_log(o_fb);
        g_dp_log = dwr_pkg::class_log(g_info.dp_h);
        o_dp_log = dwr_pkg::class_log(o_dp);
    end

    // magnification and height scaling; all ratios but the upscale factor are powers of two
    always_comb begin
        magh   = 5'({1'b0, in_item.h_mag} + 5'd1);
        magh_x = 7'({2'b0, magh} * {5'b0, hmul});
        magv   = 3'({1'b0, in_item.v_mag} + 3'd1);
        dh     = 12'({1'b0, in_item.height_m1} + 12'd1);
        if (o_fb_log >= g_fb_log) begin
            magv_n = {2'b0, magv} << (o_fb_log - g_fb_log);
        end else begin
            magv_n = {2'b0, magv} >> (g_fb_log - o_fb_log);
        end
        if (o_dp_log >= g_dp_log) begin
            dh_n = {2'b0, dh} << (o_dp_log - g_dp_log);
        end else begin
            dh_n = {2'b0, dh} >> (g_dp_log - o_dp_log);
        end
        data_next.unsup      = unsup;
        data_next.item       = in_item;
        data_next.magh       = magh;
        data_next.magh_n     = 6'(magh_x >> vshift);
        data_next.v_mag_n_m1 = 2'(magv_n - 5'd1);
        data_next.height_n   = dh_n;
        data_next.x_center   = o_info.x_center;
        data_next.y_ctr      = o_info.y_ctr;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/dwr_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwr_scale
// Second stage: forms width times new magnification for the divider and
// the centered vertical start.
// ----------------------------------------------------------------------------
module dwr_scale (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  dwr_pkg::scale_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dwr_pkg::div_t    out_data
);

    logic [12:0]     dw;
    logic [13:0]     dy;
    logic            valid_reg;
    dwr_pkg::div_t   data_reg;
    dwr_pkg::div_t   data_next;

    // product and vertical centering
    always_comb begin
        dw = 13'({1'b0, in_data.item.width_m1} + 13'd1);
        dy = 14'({2'b0, in_data.y_ctr}) - (in_data.height_n >> 1);
        data_next.unsup       = in_data.unsup;
        data_next.item        = in_data.item;
        data_next.h_mag_n_m1  = 4'(in_data.magh_n - 6'd1);
        data_next.v_mag_n_m1  = in_data.v_mag_n_m1;
        data_next.height_n_m1 = 11'(in_data.height_n - 14'd1);
        data_next.y_pos       = dy[10:0];
        data_next.x_center    = in_data.x_center;
        data_next.dividend    = dwr_pkg::DIVIDEND_W'({6'b0, dw} * {13'b0, in_data.magh_n});
        data_next.quotient    = '0;
        data_next.rem         = '0;
        data_next.divisor     = in_data.magh;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/dwr_div_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwr_div_stage
// One stage of the restoring divider: takes the next quotient bits off
// the top of the dividend, one compare and subtract per bit.
// ----------------------------------------------------------------------------
module dwr_div_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  dwr_pkg::div_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output dwr_pkg::div_t   out_data
);

    logic [4:0]      trial;
    logic            valid_reg;
    dwr_pkg::div_t   data_reg;
    dwr_pkg::div_t   data_next;

    // quotient bits, dividend shifts out at the top
    always_comb begin
        data_next = in_data;
        trial     = '0;
        for (int i = 0; i < dwr_pkg::DIV_STEPS; i++) begin
            trial = {data_next.rem, data_next.dividend[dwr_pkg::DIVIDEND_W-1]};
            data_next.dividend = data_next.dividend << 1;
            if (trial >= data_next.divisor) begin
                data_next.rem      = 4'(trial - data_next.divisor);
                data_next.quotient = {data_next.quotient[dwr_pkg::DIVIDEND_W-2:0], 1'b1};
            end else begin
                data_next.rem      = trial[3:0];
                data_next.quotient = {data_next.quotient[dwr_pkg::DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/display_window_rescaler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_window_rescaler_unit
// Rescales a display window setting from the game's video mode to the
// forced output mode and centers it on the output screen.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one window setting per item, the m_ channel one
//   result per item; m_tuser flags an unsupported mode combination, in which
//   case magnification and size pass through and the position is zero.
//   Mode registers are written over the cfg_ port; the user must do so only
//   while no item is in flight (not enforced); index 0..6 as in the register
//   list, other indexes are ignored. Stages: mode decode, product, three
//   divider stages of six quotient bits each, output register. Throughput is
//   one item per clock unless the receiver stalls; every stage holds one item,
//   the slowest being a divider stage of six compare and subtract steps.
//   When the receiver stalls, stages fill up from the output back and
//   s_tready drops only once every stage holds an item; nothing is lost.
//   Reset (aresetn low, synchronous) empties the pipeline and returns the
//   registers to 480i interlaced field mode for game and output, 240p.
// ----------------------------------------------------------------------------
module display_window_rescaler_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [dwr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dwr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // h_mag, v_mag, width_m1, height_m1
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [55:0]                     m_tdata,  // out_x_pos, out_y_pos, out_h_mag,
                                                      // out_v_mag, out_width_m1,
                                                      // out_height_m1
    output logic                            m_tuser   // mode_unsupported
);

    localparam int DIV_STAGES = dwr_pkg::DIVIDEND_W / dwr_pkg::DIV_STEPS;

    dwr_pkg::cfg_t    cfg_reg;
    dwr_pkg::item_t   in_item;

    logic             dec_valid;
    logic             dec_ready;
    dwr_pkg::scale_t  dec_data;

    logic             div_valid [DIV_STAGES+1];
    logic             div_ready [DIV_STAGES+1];
    dwr_pkg::div_t    div_data  [DIV_STAGES+1];

    logic             out_ready;
    logic             m_valid_reg;
    logic [55:0]      m_data_reg;
    logic             m_user_reg;
    logic [55:0]      m_data_next;
    logic [13:0]      dw_n;
    logic [13:0]      dw_n_m1;
    logic [13:0]      dx;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.game_mode       <= dwr_pkg::RESET_MODE;
            cfg_reg.game_interlace  <= 1'b1;
            cfg_reg.game_frame_mode <= 1'b0;
            cfg_reg.out_mode        <= dwr_pkg::RESET_MODE;
            cfg_reg.out_interlace   <= 1'b1;
            cfg_reg.out_frame_mode  <= 1'b0;
            cfg_reg.upscale_choice  <= dwr_pkg::UP_240P;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dwr_pkg::CFG_GAME_MODE:       cfg_reg.game_mode       <= cfg_wdata;
                dwr_pkg::CFG_GAME_INTERLACE:  cfg_reg.game_interlace  <= cfg_wdata[0];
                dwr_pkg::CFG_GAME_FRAME_MODE: cfg_reg.game_frame_mode <= cfg_wdata[0];
                dwr_pkg::CFG_OUT_MODE:        cfg_reg.out_mode        <= cfg_wdata;
                dwr_pkg::CFG_OUT_INTERLACE:   cfg_reg.out_interlace   <= cfg_wdata[0];
                dwr_pkg::CFG_OUT_FRAME_MODE:  cfg_reg.out_frame_mode  <= cfg_wdata[0];
                dwr_pkg::CFG_UPSCALE_CHOICE:  cfg_reg.upscale_choice  <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // unpack input item
    assign in_item.h_mag     = s_tdata[3:0];
    assign in_item.v_mag     = s_tdata[5:4];
    assign in_item.width_m1  = s_tdata[17:6];
    assign in_item.height_m1 = s_tdata[28:18];

    dwr_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    dwr_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // divider stages
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        dwr_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[s]),
            .in_ready  (div_ready[s]),
            .in_data   (div_data[s]),
            .out_valid (div_valid[s+1]),
            .out_ready (div_ready[s+1]),
            .out_data  (div_data[s+1])
        );
    end

    // horizontal centering and result packing
    always_comb begin
        dw_n    = div_data[DIV_STAGES].quotient[dwr_pkg::QUOT_W-1:0];
        dw_n_m1 = dw_n - 14'd1;
        dx      = 14'({2'b0, div_data[DIV_STAGES].x_center}) - {1'b0, dw_n[13:1]};
        if (div_data[DIV_STAGES].unsup) begin
            m_data_next = {4'b0,
                           div_data[DIV_STAGES].item.height_m1,
                           div_data[DIV_STAGES].item.width_m1,
                           div_data[DIV_STAGES].item.v_mag,
                           div_data[DIV_STAGES].item.h_mag,
                           11'd0, 12'd0};
        end else begin
            m_data_next = {4'b0,
                           div_data[DIV_STAGES].height_n_m1,
                           dw_n_m1[11:0],
                           div_data[DIV_STAGES].v_mag_n_m1,
                           div_data[DIV_STAGES].h_mag_n_m1,
                           div_data[DIV_STAGES].y_pos,
                           dx[11:0]};
        end
    end

    // output register
    assign out_ready              = !m_valid_reg || m_tready;
    assign div_ready[DIV_STAGES]  = out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && div_valid[DIV_STAGES]) begin
            m_data_reg <= m_data_next;
            m_user_reg <= div_data[DIV_STAGES].unsup;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // checks
    a_unsup_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[22:0] == 23'd0)
        else $error("unsupported result carries a window position");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid[DIV_STAGES] |->
            {1'b0, div_data[DIV_STAGES].rem} < div_data[DIV_STAGES].divisor)
        else $error("divider remainder not below divisor");

endmodule
